/* design/lbe_pkg.sv */
// lbe_pkg: shared types, constants and saturation helper for the
// lagrange basis evaluator; no dependencies
package lbe_pkg;

    localparam int MAX_NODES  = 16;
    localparam int NODE_WIDTH = 32;
    localparam int AW         = $clog2(MAX_NODES);
    localparam int VW         = 48;
    localparam int FRAC_BITS  = 30;

    localparam logic [VW-1:0] ONE_Q = 48'h0000_4000_0000;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_COINC = 2'd1;
    localparam logic [1:0] ST_SAT   = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NOP,
        OP_WR_NODE,
        OP_LATCH_IN,
        OP_LATCH_XI,
        OP_CHECK_CO,
        OP_DIV_Q,
        OP_STORE_Q,
        OP_MUL_V,
        OP_STORE_V,
        OP_INIT_P,
        OP_MUL_P,
        OP_STORE_P,
        OP_DIV_S,
        OP_ADD_S,
        OP_OUT
    } t_op;

    typedef struct packed {
        t_op           op;
        logic [AW-1:0] addr;
        logic          bad;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic mul_done;
        logic coinc;
    } t_dp_st;

    typedef struct packed {
        logic [VW-1:0] v;
        logic          s;
    } t_sat_res;

    // sign and magnitude to saturated 48 bit value
    function automatic t_sat_res f_sat(input logic neg, input logic [63:0] m,
                                       input logic over);
        t_sat_res r;
        r.s = 1'b0;
        if (neg) begin
            if (over || m > 64'h0000_8000_0000_0000) begin
                r.v = 48'h8000_0000_0000;
                r.s = 1'b1;
            end else begin
                r.v = 48'(64'd0 - m);
            end
        end else begin
            if (over || m > 64'h0000_7FFF_FFFF_FFFF) begin
                r.v = 48'h7FFF_FFFF_FFFF;
                r.s = 1'b1;
            end else begin
                r.v = m[VW-1:0];
            end
        end
        return r;
    endfunction

endpackage

/* design/lbe_div.sv */
// lbe_div: restoring divider, (num << 30) / den, one quotient bit a cycle
// depends on lbe_pkg
module lbe_div import lbe_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [48:0]   i_num,
    input  logic [32:0]   i_den,
    output logic          o_done,
    output logic [VW-1:0] o_quo,
    output logic          o_sat
);
    localparam int DW = VW + FRAC_BITS;

    logic          r_busy, r_fin, r_done;
    logic [6:0]    r_cnt;
    logic [DW-1:0] r_sh;
    logic [33:0]   r_rem;
    logic [48:0]   r_q;
    logic          r_ovf, r_neg;
    logic [32:0]   r_den;
    logic [VW-1:0] r_quo;
    logic          r_sat;

    logic [48:0]   num_mag;
    logic [32:0]   den_mag;
    logic [33:0]   trial;
    logic          ge;
    logic [48:0]   qn;
    t_sat_res      fin;

    assign num_mag = i_num[48] ? 49'd0 - i_num : i_num;
    assign den_mag = i_den[32] ? 33'd0 - i_den : i_den;
    assign trial   = {r_rem[32:0], r_sh[DW-1]};
    assign ge      = trial >= {1'b0, r_den};
    assign qn      = {r_q[47:0], ge};
    assign fin     = f_sat(r_neg, {15'd0, r_q}, r_ovf);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            r_fin  <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'(DW - 1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                r_done <= 1'b1;
            end
        end
    end

    // shift, trial subtract, quotient with sticky overflow
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sh  <= {num_mag[VW-1:0], {FRAC_BITS{1'b0}}};
            r_rem <= '0;
            r_q   <= '0;
            r_ovf <= 1'b0;
            r_neg <= i_num[48] ^ i_den[32];
            r_den <= den_mag;
        end else if (r_busy) begin
            r_sh  <= {r_sh[DW-2:0], 1'b0};
            r_rem <= ge ? trial - {1'b0, r_den} : trial;
            if (!r_ovf) begin
                r_q <= qn;
                if (qn > 49'h0_8000_0000_0000)
                    r_ovf <= 1'b1;
            end
        end
        if (r_fin) begin
            r_quo <= fin.v;
            r_sat <= fin.s;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_sat  = r_sat;
endmodule

/* design/lbe_mul.sv */
// lbe_mul: (a * b) >> 30 with saturation, 48x16 partial product a cycle
// depends on lbe_pkg
module lbe_mul import lbe_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [VW-1:0] i_a,
    input  logic [VW-1:0] i_b,
    output logic          o_done,
    output logic [VW-1:0] o_prod,
    output logic          o_sat
);
    logic          r_busy, r_fin, r_done;
    logic [1:0]    r_c;
    logic [VW-1:0] r_ma, r_mb;
    logic          r_neg;
    logic [95:0]   r_acc;
    logic [VW-1:0] r_prod;
    logic          r_sat;

    logic [15:0]   chunk;
    logic [63:0]   pp;
    logic [95:0]   pp_sh;
    t_sat_res      fin;

    // select the partial product for this step
    always_comb begin
        case (r_c)
            2'd0:    chunk = r_mb[15:0];
            2'd1:    chunk = r_mb[31:16];
            default: chunk = r_mb[47:32];
        endcase
    end
    assign pp = r_ma * chunk;
    always_comb begin
        case (r_c)
            2'd0:    pp_sh = {32'd0, pp};
            2'd1:    pp_sh = {16'd0, pp, 16'd0};
            default: pp_sh = {pp, 32'd0};
        endcase
    end
    assign fin = f_sat(r_neg, r_acc[93:30], |r_acc[95:94]);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_c    <= '0;
        end else begin
            r_fin  <= 1'b0;
            r_done <= r_fin;
            if (i_start) begin
                r_busy <= 1'b1;
                r_c    <= '0;
            end else if (r_busy) begin
                r_c <= r_c + 2'd1;
                if (r_c == 2'd2) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end
        end
    end

    // operands and accumulation
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ma  <= i_a[VW-1] ? VW'(0) - i_a : i_a;
            r_mb  <= i_b[VW-1] ? VW'(0) - i_b : i_b;
            r_neg <= i_a[VW-1] ^ i_b[VW-1];
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= r_acc + pp_sh;
        end
        if (r_fin) begin
            r_prod <= fin.v;
            r_sat  <= fin.s;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_prod;
    assign o_sat  = r_sat;
endmodule

/* design/lbe_dp.sv */
// lbe_dp: node store, quotient registers, accumulators and output register
// depends on lbe_pkg, lbe_div, lbe_mul
module lbe_dp import lbe_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    input  logic [AW-1:0]         i_node_index,
    input  logic [NODE_WIDTH-1:0] i_node_value,
    input  logic [31:0]           i_point,
    output t_dp_st                o_st,
    output logic [VW-1:0]         o_basis_value,
    output logic [VW-1:0]         o_basis_slope,
    output logic [1:0]            o_status
);
    logic [NODE_WIDTH-1:0] mem [MAX_NODES];
    logic [NODE_WIDTH-1:0] r_rd;
    logic [31:0]           r_x;
    logic [NODE_WIDTH-1:0] r_xi;
    logic [VW-1:0]         r_q [MAX_NODES];
    logic [VW-1:0]         r_val, r_p, r_slope;
    logic                  r_sat, r_coinc;
    logic [VW-1:0]         r_o_val, r_o_slope;
    logic [1:0]            r_o_status;

    logic          div_start, mul_start;
    logic [48:0]   div_num;
    logic [32:0]   div_den;
    logic          div_done, div_sat, mul_done, mul_sat;
    logic [VW-1:0] div_quo, mul_prod, mul_a;
    logic [VW:0]   sum;
    logic [VW-1:0] sum_sat;
    logic          sum_ovf;

    // node store, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_WR_NODE)
            mem[i_node_index] <= i_node_value;
        r_rd <= mem[i_cmd.addr];
    end

    // unit operands
    assign div_start = (i_cmd.op == OP_DIV_Q) || (i_cmd.op == OP_DIV_S);
    assign div_den   = {r_xi[NODE_WIDTH-1], r_xi} - {r_rd[NODE_WIDTH-1], r_rd};
    always_comb begin
        if (i_cmd.op == OP_DIV_S)
            div_num = {r_p[VW-1], r_p};
        else
            div_num = 49'(signed'({r_x[31], r_x} - {r_rd[NODE_WIDTH-1], r_rd}));
    end
    assign mul_start = (i_cmd.op == OP_MUL_V) || (i_cmd.op == OP_MUL_P);
    assign mul_a     = (i_cmd.op == OP_MUL_V) ? r_val : r_p;

    lbe_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo),
        .o_sat   (div_sat)
    );

    lbe_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (r_q[i_cmd.addr]),
        .o_done  (mul_done),
        .o_prod  (mul_prod),
        .o_sat   (mul_sat)
    );

    // saturating slope accumulate
    assign sum     = {r_slope[VW-1], r_slope} + {div_quo[VW-1], div_quo};
    assign sum_ovf = sum[VW] != sum[VW-1];
    assign sum_sat = !sum_ovf ? sum[VW-1:0] :
                     (sum[VW] ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF);

    // working registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LATCH_IN: begin
                r_x     <= i_point;
                r_val   <= ONE_Q;
                r_slope <= '0;
                r_sat   <= 1'b0;
                r_coinc <= 1'b0;
            end
            OP_LATCH_XI: r_xi <= r_rd;
            OP_CHECK_CO: if (r_rd == r_xi) r_coinc <= 1'b1;
            OP_STORE_Q: begin
                r_q[i_cmd.addr] <= div_quo;
                r_sat           <= r_sat | div_sat;
            end
            OP_STORE_V: begin
                r_val <= mul_prod;
                r_sat <= r_sat | mul_sat;
            end
            OP_INIT_P: r_p <= ONE_Q;
            OP_STORE_P: begin
                r_p   <= mul_prod;
                r_sat <= r_sat | mul_sat;
            end
            OP_ADD_S: begin
                r_slope <= sum_sat;
                r_sat   <= r_sat | div_sat | sum_ovf;
            end
            OP_OUT: begin
                if (i_cmd.bad || r_coinc) begin
                    r_o_val    <= '0;
                    r_o_slope  <= '0;
                    r_o_status <= i_cmd.bad ? ST_RANGE : ST_COINC;
                end else begin
                    r_o_val    <= r_val;
                    r_o_slope  <= r_slope;
                    r_o_status <= r_sat ? ST_SAT : ST_OK;
                end
            end
            default: ;
        endcase
    end

    assign o_st.div_done  = div_done;
    assign o_st.mul_done  = mul_done;
    assign o_st.coinc     = r_coinc;
    assign o_basis_value  = r_o_val;
    assign o_basis_slope  = r_o_slope;
    assign o_status       = r_o_status;
endmodule

/* design/lbe_ctrl.sv */
// lbe_ctrl: sequencer over the node loops, handshakes and node_count register
// depends on lbe_pkg
module lbe_ctrl import lbe_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [4:0]    i_cfg_data,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  logic          i_func,
    input  logic [AW-1:0] i_node_index,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    input  t_dp_st        i_st,
    output t_cmd          o_cmd
);
    typedef enum logic [17:0] {
        S_IDLE   = 18'b000000000000000001,
        S_XI_RD  = 18'b000000000000000010,
        S_XI_LAT = 18'b000000000000000100,
        S_CO_RD  = 18'b000000000000001000,
        S_CO_CMP = 18'b000000000000010000,
        S_CO_END = 18'b000000000000100000,
        S_Q_RD   = 18'b000000000001000000,
        S_Q_DIV  = 18'b000000000010000000,
        S_Q_WAIT = 18'b000000000100000000,
        S_V_MUL  = 18'b000000001000000000,
        S_V_WAIT = 18'b000000010000000000,
        S_P_INIT = 18'b000000100000000000,
        S_P_MUL  = 18'b000001000000000000,
        S_P_WAIT = 18'b000010000000000000,
        S_S_RD   = 18'b000100000000000000,
        S_S_DIV  = 18'b001000000000000000,
        S_S_WAIT = 18'b010000000000000000,
        S_DONE   = 18'b100000000000000000
    } t_state;

    t_state        r_state, n_state;
    logic [4:0]    r_node_count;
    logic [AW-1:0] r_i, n_i, r_k, n_k, r_j, n_j, r_nm1, n_nm1;
    logic          r_bad, n_bad;
    logic          r_out_valid, n_out_valid;

    logic [4:0]    n_eff;
    logic [AW:0]   k_nx1, k_nx2, j_nx, first1;

    // next index at or after c that skips a and b
    function automatic logic [AW:0] f_nxt(input logic [AW:0] c, input logic [AW-1:0] a,
                                          input logic [AW-1:0] b);
        logic [AW:0] r;
        r = c;
        if (r == {1'b0, a} || r == {1'b0, b}) r = r + 1'b1;
        if (r == {1'b0, a} || r == {1'b0, b}) r = r + 1'b1;
        return r;
    endfunction

    assign n_eff  = (r_node_count > 5'(MAX_NODES)) ? 5'(MAX_NODES) : r_node_count;
    assign first1 = f_nxt('0, r_i, r_i);
    assign k_nx1  = f_nxt({1'b0, r_k} + 1'b1, r_i, r_i);
    assign k_nx2  = f_nxt({1'b0, r_k} + 1'b1, r_i, r_j);
    assign j_nx   = f_nxt({1'b0, r_j} + 1'b1, r_i, r_i);

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_i         = r_i;
        n_k         = r_k;
        n_j         = r_j;
        n_nm1       = r_nm1;
        n_bad       = r_bad;
        n_out_valid = i_out_stall ? r_out_valid : 1'b0;
        o_cmd.op    = OP_NOP;
        o_cmd.addr  = r_k;
        o_cmd.bad   = r_bad;
        o_in_stall  = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (!i_func) begin
                        o_cmd.op = OP_WR_NODE;
                    end else begin
                        o_cmd.op = OP_LATCH_IN;
                        n_i      = i_node_index;
                        n_nm1    = AW'(n_eff - 5'd1);
                        n_bad    = {1'b0, i_node_index} >= n_eff;
                        n_state  = ({1'b0, i_node_index} >= n_eff) ? S_DONE : S_XI_RD;
                    end
                end
            end
            S_XI_RD: begin
                o_cmd.addr = r_i;
                n_state    = S_XI_LAT;
            end
            S_XI_LAT: begin
                o_cmd.addr = r_i;
                o_cmd.op   = OP_LATCH_XI;
                n_k        = '0;
                n_state    = S_CO_RD;
            end
            S_CO_RD: n_state = S_CO_CMP;
            S_CO_CMP: begin
                if (r_k != r_i) o_cmd.op = OP_CHECK_CO;
                if (r_k == r_nm1) begin
                    n_state = S_CO_END;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = S_CO_RD;
                end
            end
            S_CO_END: begin
                n_k = first1[AW-1:0];
                if (i_st.coinc || r_nm1 == '0) n_state = S_DONE;
                else                           n_state = S_Q_RD;
            end
            // quotients for every k other than i
            S_Q_RD: n_state = S_Q_DIV;
            S_Q_DIV: begin
                o_cmd.op = OP_DIV_Q;
                n_state  = S_Q_WAIT;
            end
            S_Q_WAIT: begin
                if (i_st.div_done) begin
                    o_cmd.op = OP_STORE_Q;
                    if (k_nx1 > {1'b0, r_nm1}) begin
                        n_k     = first1[AW-1:0];
                        n_state = S_V_MUL;
                    end else begin
                        n_k     = k_nx1[AW-1:0];
                        n_state = S_Q_RD;
                    end
                end
            end
            // basis value product
            S_V_MUL: begin
                o_cmd.op = OP_MUL_V;
                n_state  = S_V_WAIT;
            end
            S_V_WAIT: begin
                if (i_st.mul_done) begin
                    o_cmd.op = OP_STORE_V;
                    if (k_nx1 > {1'b0, r_nm1}) begin
                        n_j     = first1[AW-1:0];
                        n_state = S_P_INIT;
                    end else begin
                        n_k     = k_nx1[AW-1:0];
                        n_state = S_V_MUL;
                    end
                end
            end
            // slope term for node j
            S_P_INIT: begin
                o_cmd.op = OP_INIT_P;
                n_k      = f_nxt('0, r_i, r_j) > {1'b0, r_nm1} ? r_k :
                           AW'(f_nxt('0, r_i, r_j));
                n_state  = (f_nxt('0, r_i, r_j) > {1'b0, r_nm1}) ? S_S_RD : S_P_MUL;
            end
            S_P_MUL: begin
                o_cmd.op = OP_MUL_P;
                n_state  = S_P_WAIT;
            end
            S_P_WAIT: begin
                if (i_st.mul_done) begin
                    o_cmd.op = OP_STORE_P;
                    if (k_nx2 > {1'b0, r_nm1}) begin
                        n_state = S_S_RD;
                    end else begin
                        n_k     = k_nx2[AW-1:0];
                        n_state = S_P_MUL;
                    end
                end
            end
            S_S_RD: begin
                o_cmd.addr = r_j;
                n_state    = S_S_DIV;
            end
            S_S_DIV: begin
                o_cmd.addr = r_j;
                o_cmd.op   = OP_DIV_S;
                n_state    = S_S_WAIT;
            end
            S_S_WAIT: begin
                o_cmd.addr = r_j;
                if (i_st.div_done) begin
                    o_cmd.op = OP_ADD_S;
                    if (j_nx > {1'b0, r_nm1}) begin
                        n_state = S_DONE;
                    end else begin
                        n_j     = j_nx[AW-1:0];
                        n_state = S_P_INIT;
                    end
                end
            end
            // wait for the output register to free up
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.op    = OP_OUT;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_node_count <= 5'd16;
            r_i          <= '0;
            r_k          <= '0;
            r_j          <= '0;
            r_nm1        <= '0;
            r_bad        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_i         <= n_i;
            r_k         <= n_k;
            r_j         <= n_j;
            r_nm1       <= n_nm1;
            r_bad       <= n_bad;
            if (i_cfg_we) r_node_count <= i_cfg_data;
        end
    end

    assign o_out_valid = r_out_valid;
endmodule

/* design/lagrange_basis_eval.sv */
// lagrange_basis_eval: top level, lagrange basis value and slope over a node table
// depends on lbe_pkg, lbe_ctrl, lbe_dp
//
//   channel   handshake                 payload
//   input     i_in_valid / o_in_stall   i_func, i_node_index, i_node_value, i_point
//   output    o_out_valid / i_out_stall o_basis_value, o_basis_slope, o_status
//   config    i_cfg_we                  i_cfg_data (node_count)
//
// a load writes the node store from the idle state; the length of an evaluate is set
// by the 78-step divider that serves every quotient and the 3-step multiplier.
// an index out of range skips the node loops; coincident nodes end the evaluate after the scan.
// synchronous active-low reset sets node_count to 16; the node store is not cleared.
// the next item is taken while a result waits in the output register, and a stalled
// output holds the evaluate that follows in its final state.
module lagrange_basis_eval import lbe_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [4:0]            i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_func,
    input  logic [AW-1:0]         i_node_index,
    input  logic [NODE_WIDTH-1:0] i_node_value,
    input  logic [31:0]           i_point,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [VW-1:0]         o_basis_value,
    output logic [VW-1:0]         o_basis_slope,
    output logic [1:0]            o_status
);
    t_cmd   cmd;
    t_dp_st st;

    lbe_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_func       (i_func),
        .i_node_index (i_node_index),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_st         (st),
        .o_cmd        (cmd)
    );

    lbe_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_node_index  (i_node_index),
        .i_node_value  (i_node_value),
        .i_point       (i_point),
        .o_st          (st),
        .o_basis_value (o_basis_value),
        .o_basis_slope (o_basis_slope),
        .o_status      (o_status)
    );
endmodule

/* design/lbe_checker.sv */
// lbe_checker: port-level assertions for lagrange_basis_eval, bound to the top level
// depends on lbe_pkg
module lbe_checker import lbe_pkg::*; (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_stall,
    input logic          i_func,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input logic [VW-1:0] o_basis_value,
    input logic [VW-1:0] o_basis_slope,
    input logic [1:0]    o_status
);
    // error results carry zero fields
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_RANGE || o_status == ST_COINC)
        |-> o_basis_value == '0 && o_basis_slope == '0)
        else $error("error result with nonzero fields");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(o_out_valid && i_out_stall)
        |-> o_out_valid && $stable(o_basis_value) && $stable(o_status))
        else $error("stalled result changed");

    // an evaluate keeps the input stalled while it runs
    a_eval_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(i_in_valid && !o_in_stall && i_func) |-> o_in_stall)
        else $error("input taken during evaluate");

    // nothing valid right after reset
    a_rst_idle: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_out_valid)
        else $error("result valid after reset");
endmodule

bind lagrange_basis_eval lbe_checker u_lbe_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .i_func        (i_func),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_basis_value (o_basis_value),
    .o_basis_slope (o_basis_slope),
    .o_status      (o_status)
);
